FILE: sv/sliding_history_histogram_defines.svh
// Assertion macros shared by the checker of the sliding history histogram.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SLIDING_HISTORY_HISTOGRAM_DEFINES_SVH
`define SLIDING_HISTORY_HISTOGRAM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHH_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("shh checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define SHH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("shh checker: next-cycle property failed");

`endif

FILE: sv/shh_pkg.sv
// Package of the sliding history histogram: defaults, codes and the
// command and status structs between controller and datapath. No dependencies.
package shh_pkg;

    localparam int DEF_STATE_BITS  = 12;
    localparam int DEF_SYMBOL_BITS = 4;
    localparam int DEF_MAX_HISTORY = 11;
    localparam int DEF_COUNT_BITS  = 32;

    localparam int BASE_W      = 5;
    localparam int KLEN_W      = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [BASE_W-1:0] BASE_RESET = 5'd2;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SYMBOL_BASE,
        CFG_HISTORY_LENGTH
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ_STATE,
        OP_READ_HIST,
        OP_CLEAR
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_SYMBOL,
        ST_BAD_CONFIG
    } status_t;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_POW,
        S_EVAL,
        S_READ,
        S_UPDATE,
        S_CLR,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic pow_start;
        logic pow_step;
        logic eval;
        logic mem_read;
        logic update;
        logic clr_step;
        logic load_out;
    } shh_cmd_t;

    typedef struct packed {
        logic cfg_cached;
        logic pow_last;
        logic observe;
        logic clr_last;
        logic out_free;
    } shh_stat_t;

endpackage

FILE: sv/shh_item_if.sv
// Input channel of the sliding history histogram: valid, ready and one item.
// Depends on shh_pkg for default widths.
interface shh_item_if #(
    parameter int STATE_BITS  = shh_pkg::DEF_STATE_BITS,
    parameter int SYMBOL_BITS = shh_pkg::DEF_SYMBOL_BITS
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             opcode;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   new_series;
    logic [STATE_BITS-1:0]  read_index;

    modport source (output valid, opcode, symbol, new_series, read_index, input ready);
    modport sink   (input valid, opcode, symbol, new_series, read_index, output ready);
endinterface

FILE: sv/shh_result_if.sv
// Output channel of the sliding history histogram: valid, ready and one result item.
// Depends on shh_pkg for default widths.
interface shh_result_if #(
    parameter int STATE_BITS = shh_pkg::DEF_STATE_BITS,
    parameter int COUNT_BITS = shh_pkg::DEF_COUNT_BITS
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic                  observed;
    logic [STATE_BITS-1:0] state_code;
    logic [STATE_BITS-2:0] history_code;
    logic [COUNT_BITS-1:0] count;
    logic [COUNT_BITS-1:0] total;

    modport source (output valid, status, observed, state_code, history_code, count, total,
                    input ready);
    modport sink   (input valid, status, observed, state_code, history_code, count, total,
                    output ready);
endinterface

FILE: sv/shh_ctrl.sv
// Controller of the sliding history histogram: sequences each item through the datapath.
// Depends on shh_pkg for the state, command and status types.
module shh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        opcode,
    input  shh_pkg::shh_stat_t stat,
    output logic              in_ready,
    output shh_pkg::shh_cmd_t cmd
);

    shh_pkg::ctrl_state_t state_reg;
    shh_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shh_pkg::S_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            shh_pkg::S_INIT_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = shh_pkg::S_IDLE;
                end
            end
            shh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    unique case (shh_pkg::opcode_t'(opcode)) inside
                        shh_pkg::OP_PUSH:
                        begin
                            if (stat.cfg_cached)
                            begin
                                state_next = shh_pkg::S_EVAL;
                            end
                            else
                            begin
                                cmd.pow_start = 1'b1;
                                state_next    = shh_pkg::S_POW;
                            end
                        end
                        shh_pkg::OP_READ_STATE, shh_pkg::OP_READ_HIST:
                        begin
                            state_next = shh_pkg::S_READ;
                        end
                        shh_pkg::OP_CLEAR:
                        begin
                            state_next = shh_pkg::S_CLR;
                        end
                    endcase
                end
            end
            shh_pkg::S_POW:
            begin
                cmd.pow_step = 1'b1;
                if (stat.pow_last)
                begin
                    state_next = shh_pkg::S_EVAL;
                end
            end
            shh_pkg::S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.observe ? shh_pkg::S_READ : shh_pkg::S_DONE;
            end
            shh_pkg::S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = shh_pkg::S_UPDATE;
            end
            shh_pkg::S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = shh_pkg::S_DONE;
            end
            shh_pkg::S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = shh_pkg::S_DONE;
                end
            end
            shh_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = shh_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: sv/shh_datapath.sv
// Datapath of the sliding history histogram: configuration, history window,
// power unit, both count memories and the output register. Depends on shh_pkg.
module shh_datapath #(
    parameter int STATE_BITS  = shh_pkg::DEF_STATE_BITS,
    parameter int SYMBOL_BITS = shh_pkg::DEF_SYMBOL_BITS,
    parameter int MAX_HISTORY = shh_pkg::DEF_MAX_HISTORY,
    parameter int COUNT_BITS  = shh_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [shh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shh_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [1:0]                     opcode,
    input  logic [SYMBOL_BITS-1:0]         symbol,
    input  logic                           new_series,
    input  logic [STATE_BITS-1:0]          read_index,
    input  shh_pkg::shh_cmd_t              cmd,
    output shh_pkg::shh_stat_t             stat,
    input  logic                           result_ready,
    output logic                           result_valid,
    output logic [1:0]                     status,
    output logic                           observed,
    output logic [STATE_BITS-1:0]          state_code,
    output logic [STATE_BITS-2:0]          history_code,
    output logic [COUNT_BITS-1:0]          count,
    output logic [COUNT_BITS-1:0]          total
);

    localparam int HB          = STATE_BITS - 1;
    localparam int STATE_DEPTH = 1 << STATE_BITS;
    localparam int HIST_DEPTH  = 1 << HB;
    localparam int BASE_W      = shh_pkg::BASE_W;
    localparam int KLEN_W      = shh_pkg::KLEN_W;
    localparam int FILL_W      = $clog2(MAX_HISTORY + 1);
    localparam int CMP_W       = (FILL_W > KLEN_W) ? FILL_W : KLEN_W;
    localparam int SCW         = (SYMBOL_BITS > BASE_W) ? SYMBOL_BITS : BASE_W;
    localparam int WIN_IW      = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
    localparam int MUL_W       = HB + BASE_W + SYMBOL_BITS;
    localparam int PW          = STATE_BITS + 1 + BASE_W;
    localparam int DW          = SYMBOL_BITS + STATE_BITS;
    localparam logic [PW-1:0] POW_LIMIT = PW'(1) << STATE_BITS;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Configuration, window and control registers.
    logic [BASE_W-1:0]      base_reg;
    logic [KLEN_W-1:0]      klen_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [HB-1:0]          hist_reg;
    logic [SYMBOL_BITS-1:0] win_reg [MAX_HISTORY];
    logic [COUNT_BITS-1:0]  total_reg;
    logic                   cached_reg;
    logic                   cfg_ok_reg;
    logic                   out_valid_reg;
    logic [STATE_BITS-1:0]  clr_cnt_reg;

    // Item and working registers.
    shh_pkg::opcode_t       op_reg;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic                   fresh_reg;
    logic [STATE_BITS-1:0]  idx_reg;
    logic [STATE_BITS:0]    pow_p_reg;
    logic [KLEN_W-1:0]      pow_cnt_reg;
    logic                   pow_ovf_reg;
    logic [STATE_BITS-1:0]  q_reg;
    logic [STATE_BITS-1:0]  s_reg;
    logic [HB-1:0]          h_reg;
    logic [DW-1:0]          drop_reg;
    logic [COUNT_BITS-1:0]  st_rd_reg;
    logic [COUNT_BITS-1:0]  hi_rd_reg;

    shh_pkg::status_t       res_status_reg;
    logic                   res_obs_reg;
    logic [STATE_BITS-1:0]  res_scode_reg;
    logic [HB-1:0]          res_hcode_reg;
    logic [COUNT_BITS-1:0]  res_count_reg;

    shh_pkg::status_t       out_status_reg;
    logic                   out_obs_reg;
    logic [STATE_BITS-1:0]  out_scode_reg;
    logic [HB-1:0]          out_hcode_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic [COUNT_BITS-1:0]  out_total_reg;

    logic [COUNT_BITS-1:0]  st_mem [STATE_DEPTH];
    logic [COUNT_BITS-1:0]  hi_mem [HIST_DEPTH];

    logic                   sym_bad;
    logic                   pre_bad;
    logic [HB-1:0]          h_eff;
    logic [FILL_W-1:0]      f_eff;
    logic                   warm;
    logic [MUL_W-1:0]       hb_sum;
    logic [PW-1:0]          pow_prod;
    logic                   pow_big;
    logic                   pow_last;
    logic [KLEN_W-1:0]      klen_m1;
    logic [WIN_IW-1:0]      win_idx;
    logic [SYMBOL_BITS-1:0] win_sel;
    logic [DW-1:0]          diff;
    logic                   s_ge_drop;
    logic                   is_push;
    logic                   st_we;
    logic                   hi_we;
    logic [STATE_BITS-1:0]  st_waddr;
    logic [HB-1:0]          hi_waddr;
    logic [COUNT_BITS-1:0]  st_wdata;
    logic [COUNT_BITS-1:0]  hi_wdata;
    logic [STATE_BITS-1:0]  st_raddr;
    logic [HB-1:0]          hi_raddr;

    always_comb
    begin
        is_push   = (op_reg == shh_pkg::OP_PUSH);
        sym_bad   = SCW'(sym_reg) >= SCW'(base_reg);
        pre_bad   = (base_reg < BASE_W'(2)) || (klen_reg == '0) || (int'(klen_reg) > MAX_HISTORY);
        h_eff     = fresh_reg ? '0 : hist_reg;
        f_eff     = fresh_reg ? '0 : fill_reg;
        warm      = CMP_W'(f_eff) < CMP_W'(klen_reg);
        hb_sum    = MUL_W'(h_eff) * MUL_W'(base_reg) + MUL_W'(sym_reg);
        pow_prod  = PW'(pow_p_reg) * PW'(base_reg);
        pow_big   = pow_prod > POW_LIMIT;
        pow_last  = pre_bad || (pow_cnt_reg == klen_reg);
        klen_m1   = klen_reg - 1'b1;
        win_idx   = WIN_IW'(klen_m1);
        win_sel   = win_reg[win_idx];
        diff      = DW'(s_reg) - drop_reg;
        s_ge_drop = DW'(s_reg) >= drop_reg;

        st_we    = cmd.clr_step || (cmd.update && is_push);
        hi_we    = st_we;
        st_waddr = cmd.clr_step ? clr_cnt_reg : s_reg;
        hi_waddr = cmd.clr_step ? clr_cnt_reg[HB-1:0] : h_reg;
        st_wdata = cmd.clr_step ? '0 : sat_inc(st_rd_reg);
        hi_wdata = cmd.clr_step ? '0 : sat_inc(hi_rd_reg);
        st_raddr = is_push ? s_reg : idx_reg;
        hi_raddr = is_push ? h_reg : idx_reg[HB-1:0];

        stat.cfg_cached = cached_reg;
        stat.pow_last   = pow_last;
        stat.observe    = cfg_ok_reg && !sym_bad && !warm;
        stat.clr_last   = &clr_cnt_reg;
        stat.out_free   = !out_valid_reg || result_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= shh_pkg::BASE_RESET;
            klen_reg      <= shh_pkg::KLEN_RESET;
            fill_reg      <= '0;
            hist_reg      <= '0;
            win_reg       <= '{default: '0};
            total_reg     <= '0;
            cached_reg    <= 1'b0;
            cfg_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.pow_step && pow_last)
            begin
                cached_reg <= 1'b1;
                cfg_ok_reg <= !pre_bad && !pow_ovf_reg && !pow_big;
            end
            if (cmd.eval && cfg_ok_reg && !sym_bad)
            begin
                if (warm)
                begin
                    hist_reg <= hb_sum[HB-1:0];
                    fill_reg <= f_eff + 1'b1;
                end
                for (int i = 1; i < MAX_HISTORY; i++)
                begin
                    win_reg[i] <= win_reg[i-1];
                end
                win_reg[0] <= sym_reg;
            end
            if (cmd.mem_read && is_push)
            begin
                hist_reg <= s_ge_drop ? diff[HB-1:0] : '0;
            end
            if (cmd.update && is_push)
            begin
                total_reg <= sat_inc(total_reg);
            end
            if (cmd.clr_step)
            begin
                total_reg   <= '0;
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == shh_pkg::CFG_SYMBOL_BASE)
                begin
                    base_reg <= cfg_data[BASE_W-1:0];
                end
                else
                begin
                    klen_reg <= cfg_data[KLEN_W-1:0];
                end
                fill_reg   <= '0;
                hist_reg   <= '0;
                cached_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg         <= shh_pkg::opcode_t'(opcode);
            sym_reg        <= symbol;
            fresh_reg      <= new_series;
            idx_reg        <= read_index;
            res_status_reg <= shh_pkg::ST_OK;
            res_obs_reg    <= 1'b0;
            res_scode_reg  <= '0;
            res_hcode_reg  <= '0;
            res_count_reg  <= '0;
        end
        if (cmd.pow_start)
        begin
            pow_p_reg   <= (STATE_BITS + 1)'(1);
            pow_cnt_reg <= '0;
            pow_ovf_reg <= 1'b0;
        end
        if (cmd.pow_step)
        begin
            if (pow_last)
            begin
                q_reg <= pow_p_reg[STATE_BITS-1:0];
            end
            else
            begin
                if (pow_big)
                begin
                    pow_ovf_reg <= 1'b1;
                end
                else
                begin
                    pow_p_reg <= pow_prod[STATE_BITS:0];
                end
                pow_cnt_reg <= pow_cnt_reg + 1'b1;
            end
        end
        if (cmd.eval)
        begin
            if (!cfg_ok_reg)
            begin
                res_status_reg <= shh_pkg::ST_BAD_CONFIG;
            end
            else if (sym_bad)
            begin
                res_status_reg <= shh_pkg::ST_BAD_SYMBOL;
            end
            else if (!warm)
            begin
                res_obs_reg   <= 1'b1;
                res_scode_reg <= hb_sum[STATE_BITS-1:0];
                res_hcode_reg <= h_eff;
                s_reg         <= hb_sum[STATE_BITS-1:0];
                h_reg         <= h_eff;
                drop_reg      <= DW'(win_sel) * DW'(q_reg);
            end
        end
        if (cmd.mem_read)
        begin
            if (op_reg == shh_pkg::OP_READ_STATE)
            begin
                res_scode_reg <= idx_reg;
            end
            if (op_reg == shh_pkg::OP_READ_HIST)
            begin
                res_hcode_reg <= idx_reg[HB-1:0];
            end
        end
        if (cmd.update)
        begin
            case (op_reg)
                shh_pkg::OP_PUSH:       res_count_reg <= sat_inc(st_rd_reg);
                shh_pkg::OP_READ_STATE: res_count_reg <= st_rd_reg;
                shh_pkg::OP_READ_HIST:  res_count_reg <= idx_reg[STATE_BITS-1] ? '0 : hi_rd_reg;
                default:                res_count_reg <= res_count_reg;
            endcase
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_obs_reg    <= res_obs_reg;
            out_scode_reg  <= res_scode_reg;
            out_hcode_reg  <= res_hcode_reg;
            out_count_reg  <= res_count_reg;
            out_total_reg  <= total_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (cmd.mem_read)
        begin
            st_rd_reg <= st_mem[st_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hi_we)
        begin
            hi_mem[hi_waddr] <= hi_wdata;
        end
        if (cmd.mem_read)
        begin
            hi_rd_reg <= hi_mem[hi_raddr];
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign observed     = out_obs_reg;
    assign state_code   = out_scode_reg;
    assign history_code = out_hcode_reg;
    assign count        = out_count_reg;
    assign total        = out_total_reg;

endmodule

FILE: sv/sliding_history_histogram.sv
// Top level of the sliding history histogram: controller plus datapath.
// Depends on shh_pkg, shh_item_if, shh_result_if, shh_ctrl and shh_datapath.
//
// Symbols pushed through the item channel build a base-b history of the last
// k symbols; after warm-up each push counts the state code history*b+symbol
// and its history in two saturating histograms held in single-port memories.
// Every item but a clear passes through a controller that visits the memories
// at most once. Once accepted, a push that counts an observation goes through
// evaluation, a memory read, an update and a final state; a rejected push or
// one still warming up goes from evaluation to the final state, and a read
// skips evaluation. The first push after reset or after a register write also
// runs the power multiplier k+1 times to form b^k and check b^(k+1) against the
// state table, or stops at its first step when the base or the length is out of
// range. A clear item sweeps both memories one entry a cycle; the same sweep
// runs after reset, and no item is accepted until it ends. The result register
// lets the next item be accepted while the previous result still waits to be
// taken; an item whose result is ready while the previous one is still held
// waits in its last cycle until the result channel takes it.
module sliding_history_histogram #(
    parameter int STATE_BITS  = shh_pkg::DEF_STATE_BITS,
    parameter int SYMBOL_BITS = shh_pkg::DEF_SYMBOL_BITS,
    parameter int MAX_HISTORY = shh_pkg::DEF_MAX_HISTORY,
    parameter int COUNT_BITS  = shh_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [shh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shh_pkg::CFG_DATA_W-1:0]  cfg_data,
    shh_item_if.sink                        items,
    shh_result_if.source                    results
);

    shh_pkg::shh_cmd_t  cmd;
    shh_pkg::shh_stat_t stat;

    shh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .opcode   (items.opcode),
        .stat     (stat),
        .in_ready (items.ready),
        .cmd      (cmd)
    );

    shh_datapath #(
        .STATE_BITS  (STATE_BITS),
        .SYMBOL_BITS (SYMBOL_BITS),
        .MAX_HISTORY (MAX_HISTORY),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .opcode       (items.opcode),
        .symbol       (items.symbol),
        .new_series   (items.new_series),
        .read_index   (items.read_index),
        .cmd          (cmd),
        .stat         (stat),
        .result_ready (results.ready),
        .result_valid (results.valid),
        .status       (results.status),
        .observed     (results.observed),
        .state_code   (results.state_code),
        .history_code (results.history_code),
        .count        (results.count),
        .total        (results.total)
    );

endmodule

FILE: sv/shh_checker.sv
// Port-level checker of the sliding history histogram and its bind statement.
// Depends on shh_pkg and sliding_history_histogram_defines.svh.
`include "sliding_history_histogram_defines.svh"

module shh_port_checker #(
    parameter int STATE_BITS = shh_pkg::DEF_STATE_BITS,
    parameter int COUNT_BITS = shh_pkg::DEF_COUNT_BITS
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_ready,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic [1:0]            status,
    input logic                  observed,
    input logic [STATE_BITS-1:0] state_code,
    input logic [COUNT_BITS-1:0] count
);

    logic status_ok;
    logic obs_ok;
    logic result_clean;

    assign status_ok    = (status == shh_pkg::ST_OK);
    assign obs_ok       = status_ok && (count != '0);
    assign result_clean = !observed && (state_code == '0) && (count == '0);

    // A result that is not taken stays offered.
    `SHH_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)

    // An observation is always a successful push that counted at least once.
    `SHH_ASSERT_SAME(a_observed_counted, clk, rst_n, result_valid && observed, obs_ok)

    // A rejected push reports no code and no count.
    `SHH_ASSERT_SAME(a_reject_clean, clk, rst_n, result_valid && !status_ok, result_clean)

    // The clearing pass after reset keeps the item channel closed.
    `SHH_ASSERT_SAME(a_reset_sweep, clk, rst_n, $rose(rst_n), !item_ready)

endmodule

bind sliding_history_histogram shh_port_checker #(
    .STATE_BITS (STATE_BITS),
    .COUNT_BITS (COUNT_BITS)
) u_shh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (items.ready),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .status       (results.status),
    .observed     (results.observed),
    .state_code   (results.state_code),
    .count        (results.count)
);

FILE: verif/shh_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the sliding history histogram: follows register writes and both channels,
// predicts every result item and compares it field by field with what the block returns.
// Depends on shh_pkg, shh_item_if and shh_result_if.
module shh_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [shh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shh_pkg::CFG_DATA_W-1:0]  cfg_data,
    shh_item_if                             items,
    shh_result_if                           results,
    output int                              errors,
    output int                              pending,
    output int                              checked,
    output int                              observations
);

    localparam int STATE_BITS  = shh_pkg::DEF_STATE_BITS;
    localparam int HIST_BITS   = shh_pkg::DEF_STATE_BITS - 1;
    localparam int SYMBOL_BITS = shh_pkg::DEF_SYMBOL_BITS;
    localparam int MAX_HISTORY = shh_pkg::DEF_MAX_HISTORY;
    localparam int COUNT_BITS  = shh_pkg::DEF_COUNT_BITS;
    localparam int STATE_DEPTH = 1 << STATE_BITS;
    localparam int HIST_DEPTH  = 1 << HIST_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        shh_pkg::status_t      status;
        logic                  observed;
        logic [STATE_BITS-1:0] state_code;
        logic [HIST_BITS-1:0]  history_code;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] total;
    } outcome_t;

    logic [shh_pkg::BASE_W-1:0] base_reg;
    logic [shh_pkg::KLEN_W-1:0] klen_reg;
    logic [SYMBOL_BITS-1:0]     window [MAX_HISTORY];
    logic [HIST_BITS-1:0]       history;
    logic [shh_pkg::KLEN_W-1:0] filled;
    logic [COUNT_BITS-1:0]      state_hist [STATE_DEPTH];
    logic [COUNT_BITS-1:0]      history_hist [HIST_DEPTH];
    logic [COUNT_BITS-1:0]      total_obs;
    outcome_t                   expected_outcomes [$];
    int                         mismatch_count;
    int                         checked_count;
    int                         observed_count;

    function automatic logic [COUNT_BITS-1:0] saturating_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Valid when b >= 2, 1 <= k <= MAX_HISTORY and b^(k+1) fits the state table.
    function automatic bit table_fits(output logic [63:0] pow_k);
        logic [63:0] p;
        p = 64'd1;
        pow_k = 64'd1;
        if (base_reg < 2 || klen_reg == 0 || klen_reg > MAX_HISTORY)
            return 1'b0;
        for (int i = 0; i < klen_reg; i++)
            p = p * base_reg;
        pow_k = p;
        return (p * base_reg) <= STATE_DEPTH;
    endfunction

    function automatic outcome_t histogram_step(input shh_pkg::opcode_t op,
                                                input logic [SYMBOL_BITS-1:0] sym,
                                                input logic fresh,
                                                input logic [STATE_BITS-1:0] idx);
        outcome_t              r;
        logic [63:0]           pow_k;
        logic [63:0]           drop;
        logic [HIST_BITS-1:0]  h;
        logic [STATE_BITS-1:0] s;
        r = '0;
        case (op)
            shh_pkg::OP_PUSH:
            begin
                if (!table_fits(pow_k))
                    r.status = shh_pkg::ST_BAD_CONFIG;
                else if (sym >= base_reg)
                    r.status = shh_pkg::ST_BAD_SYMBOL;
                else
                begin
                    if (fresh)
                    begin
                        filled = '0;
                        history = '0;
                    end
                    if (filled < klen_reg)
                    begin
                        history = HIST_BITS'(32'(history) * base_reg + sym);
                        filled = filled + 1'b1;
                    end
                    else
                    begin
                        h = history;
                        s = STATE_BITS'(32'(h) * base_reg + sym);
                        drop = 64'(window[klen_reg - 1]) * pow_k;
                        state_hist[s] = saturating_inc(state_hist[s]);
                        history_hist[h] = saturating_inc(history_hist[h]);
                        total_obs = saturating_inc(total_obs);
                        history = (64'(s) >= drop) ? HIST_BITS'(64'(s) - drop) : '0;
                        r.observed = 1'b1;
                        r.state_code = s;
                        r.history_code = h;
                        r.count = state_hist[s];
                        observed_count++;
                    end
                    for (int i = MAX_HISTORY - 1; i > 0; i--)
                        window[i] = window[i - 1];
                    window[0] = sym;
                end
            end
            shh_pkg::OP_READ_STATE:
            begin
                r.state_code = idx;
                r.count = state_hist[idx];
            end
            shh_pkg::OP_READ_HIST:
            begin
                r.history_code = idx[HIST_BITS-1:0];
                r.count = (idx < HIST_DEPTH) ? history_hist[idx[HIST_BITS-1:0]] : '0;
            end
            default:
            begin
                foreach (state_hist[i])
                    state_hist[i] = '0;
                foreach (history_hist[i])
                    history_hist[i] = '0;
                total_obs = '0;
            end
        endcase
        r.total = total_obs;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        outcome_t seen;
        if (!rst_n)
        begin
            base_reg = shh_pkg::BASE_RESET;
            klen_reg = shh_pkg::KLEN_RESET;
            foreach (window[i])
                window[i] = '0;
            history = '0;
            filled = '0;
            foreach (state_hist[i])
                state_hist[i] = '0;
            foreach (history_hist[i])
                history_hist[i] = '0;
            total_obs = '0;
            expected_outcomes.delete();
            mismatch_count = 0;
            checked_count = 0;
            observed_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == shh_pkg::CFG_SYMBOL_BASE)
                    base_reg = cfg_data;
                else
                    klen_reg = cfg_data[shh_pkg::KLEN_W-1:0];
                filled = '0;
                history = '0;
            end
            if (results.valid && results.ready)
            begin
                seen.status = shh_pkg::status_t'(results.status);
                seen.observed = results.observed;
                seen.state_code = results.state_code;
                seen.history_code = results.history_code;
                seen.count = results.count;
                seen.total = results.total;
                if (expected_outcomes.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display({"[%0t] result item with no expectation: ",
                                  "st %0d obs %0d sc %0d hc %0d cnt %0d tot %0d"},
                                 $time, seen.status, seen.observed, seen.state_code,
                                 seen.history_code, seen.count, seen.total);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    checked_count++;
                    if (seen !== want)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display({"[%0t] mismatch, expected ",
                                      "st %0d obs %0d sc %0d hc %0d cnt %0d tot %0d"},
                                     $time, want.status, want.observed, want.state_code,
                                     want.history_code, want.count, want.total);
                            $display({"[%0t]           actual   ",
                                      "st %0d obs %0d sc %0d hc %0d cnt %0d tot %0d"},
                                     $time, seen.status, seen.observed, seen.state_code,
                                     seen.history_code, seen.count, seen.total);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (items.valid && items.ready)
                expected_outcomes.push_back(
                    histogram_step(shh_pkg::opcode_t'(items.opcode), items.symbol,
                                   items.new_series, items.read_index));
        end
        errors <= mismatch_count;
        pending <= expected_outcomes.size();
        checked <= checked_count;
        observations <= observed_count;
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the sliding history histogram testbench: clock, reset, register writes, item
// stimulus with random idling on both channels, and the verdict.
// Depends on shh_pkg, the channel interfaces, sliding_history_histogram and shh_checker.
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_AFTER     = 500;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 16;
    localparam int PHASE_BASE  [PHASES] = '{2, 16, 2, 3, 4, 6, 31, 16, 0, 1, 5, 2, 3, 8, 2, 7};
    localparam int PHASE_KLEN  [PHASES] = '{1, 2, 11, 3, 5, 3, 1, 3, 4, 2, 0, 12, 15, 3, 1, 2};
    localparam int PHASE_ITEMS [PHASES] = '{200, 220, 220, 160, 160, 160, 120, 30,
                                            25, 25, 25, 25, 25, 160, 160, 120};

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [shh_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [shh_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              errors;
    int                              pending;
    int                              checked;
    int                              observations;
    int                              sent = 0;
    int                              clears = 0;
    int                              taken = 0;
    int                              stall_cycles = 0;
    int                              cur_base = 2;
    int                              cur_klen = 1;
    bit                              send_idles = 1'b0;

    shh_item_if   items ();
    shh_result_if results ();

    sliding_history_histogram dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .results   (results)
    );

    shh_checker score (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .items        (items),
        .results      (results),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked),
        .observations (observations)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no item moved for %0d cycles", stall_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Result side: a random wait before each item, quiet stretches, and one long hold-off.
    initial
    begin
        int  wait_cycles;
        bit  rcv_idles;
        bit  hold_done;
        rcv_idles = 1'b1;
        hold_done = 1'b0;
        results.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (taken % 64 == 0)
                rcv_idles = ($urandom_range(0, 2) != 0);
            if (!hold_done && taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                wait_cycles = HOLD_CYCLES;
            end
            else
                wait_cycles = rcv_idles ? $urandom_range(0, 7) : 0;
            if (wait_cycles > 0)
            begin
                results.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            results.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results.valid);
            taken++;
        end
    end

    task automatic send_item(input shh_pkg::opcode_t op, input logic [3:0] sym,
                             input logic fresh, input logic [11:0] idx);
        int gap;
        if (sent % 64 == 0)
            send_idles = ($urandom_range(0, 2) != 0);
        gap = send_idles ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.opcode <= op;
        items.symbol <= sym;
        items.new_series <= fresh;
        items.read_index <= idx;
        do
            @(posedge clk);
        while (!items.ready);
        sent++;
        if (op == shh_pkg::OP_CLEAR)
            clears++;
    endtask

    task automatic drain();
        items.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic int table_span();
        int span;
        span = cur_base;
        for (int i = 0; i < cur_klen && span <= 4096; i++)
            span = span * cur_base;
        return (cur_base < 2 || span > 4096) ? 4096 : span;
    endfunction

    initial
    begin
        int pick;
        int run_left;
        int span;
        int sym_top;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= shh_pkg::CFG_SYMBOL_BASE;
        cfg_data <= '0;
        items.valid <= 1'b0;
        items.opcode <= shh_pkg::OP_PUSH;
        items.symbol <= '0;
        items.new_series <= 1'b0;
        items.read_index <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting, base 2 and one symbol of history.
        send_item(shh_pkg::OP_READ_STATE, 4'd0, 1'b0, 12'd4095);
        send_item(shh_pkg::OP_READ_HIST, 4'd0, 1'b0, 12'd2047);
        send_item(shh_pkg::OP_READ_HIST, 4'd0, 1'b0, 12'd2048);
        send_item(shh_pkg::OP_READ_HIST, 4'd15, 1'b1, 12'd4095);
        send_item(shh_pkg::OP_PUSH, 4'd0, 1'b1, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd1, 1'b0, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd1, 1'b0, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd0, 1'b0, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd2, 1'b0, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd15, 1'b1, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd1, 1'b0, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd1, 1'b1, 12'd0);
        send_item(shh_pkg::OP_PUSH, 4'd0, 1'b0, 12'd0);
        send_item(shh_pkg::OP_READ_STATE, 4'd0, 1'b0, 12'd2);
        send_item(shh_pkg::OP_READ_STATE, 4'd0, 1'b0, 12'd1);
        send_item(shh_pkg::OP_READ_HIST, 4'd0, 1'b0, 12'd1);
        send_item(shh_pkg::OP_READ_HIST, 4'd0, 1'b0, 12'd0);
        send_item(shh_pkg::OP_CLEAR, 4'd0, 1'b0, 12'd0);
        send_item(shh_pkg::OP_READ_STATE, 4'd0, 1'b0, 12'd1);
        send_item(shh_pkg::OP_PUSH, 4'd1, 1'b0, 12'd0);
        send_item(shh_pkg::OP_READ_STATE, 4'd0, 1'b0, 12'd0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= shh_pkg::CFG_SYMBOL_BASE;
            cfg_data <= shh_pkg::CFG_DATA_W'(PHASE_BASE[p]);
            @(posedge clk);
            cfg_index <= shh_pkg::CFG_HISTORY_LENGTH;
            cfg_data <= shh_pkg::CFG_DATA_W'(PHASE_KLEN[p]);
            @(posedge clk);
            cfg_we <= 1'b0;
            cur_base = PHASE_BASE[p];
            cur_klen = PHASE_KLEN[p];
            span = table_span();
            sym_top = (cur_base < 2 || cur_base > 16) ? 15 : cur_base - 1;
            run_left = 0;
            // Mostly well-formed series of valid symbols, with reads, noise and rare clears.
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
            begin
                pick = $urandom_range(0, 999);
                if (pick < 4)
                    send_item(shh_pkg::OP_CLEAR, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 12'($urandom));
                else if (pick < 150)
                    send_item(shh_pkg::OP_READ_STATE, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, span - 1))
                                                          : 12'($urandom));
                else if (pick < 250)
                    send_item(shh_pkg::OP_READ_HIST, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)),
                              ($urandom_range(0, 3) != 0)
                                  ? 12'($urandom_range(0, span / (sym_top + 1) - 1))
                                  : 12'($urandom));
                else if (pick < 300)
                    send_item(shh_pkg::OP_PUSH, 4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 12'($urandom));
                else
                begin
                    send_item(shh_pkg::OP_PUSH, 4'($urandom_range(0, sym_top)), run_left == 0,
                              12'($urandom));
                    if (run_left == 0)
                        run_left = $urandom_range(1, 48);
                    run_left--;
                end
            end
            drain();
        end

        $display("Sent %0d items (%0d clears) over %0d register settings plus the reset one;",
                 sent, clears, PHASES);
        $display("%0d results checked, %0d of them counted observations.", checked, observations);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
